// File: hdl/bfiq_pkg.sv
package bfiq_pkg;

    // store size and round limits
    localparam int MAX_BITS   = 1024;
    localparam int MAX_HASHES = 16;

    // store address, modulus and round counter widths
    localparam int BIT_AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int MOD_W  = BIT_AW + 1;
    localparam int RCNT_W = $clog2(MAX_HASHES + 1);

    // key layout: the round number is xored in at ROUND_SHIFT
    localparam int KEY_W       = 32;
    localparam int ROUND_SHIFT = 16;
    localparam int RND_BITS    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

    // remainder unit takes DIG key bits per cycle
    localparam int DIG       = 4;
    localparam int PRE_W     = ((KEY_W - ROUND_SHIFT - RND_BITS) / DIG) * DIG;
    localparam int LOW_W     = KEY_W - PRE_W;
    localparam int PRE_STEPS = PRE_W / DIG;
    localparam int LOW_STEPS = LOW_W / DIG;
    localparam int DCNT_W    = (LOW_STEPS > 1) ? $clog2(LOW_STEPS) : 1;

    // configuration registers
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;
    localparam int FB_W       = 11;
    localparam int HC_W       = 5;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = CFG_IDX_W'(1);
    localparam logic [FB_W-1:0]      FB_RESET        = FB_W'(1024);
    localparam logic [HC_W-1:0]      HC_RESET        = HC_W'(10);

    // stream payload widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // mode codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // store access issued by the sequencer
    typedef struct packed {
        logic              en;
        logic              we;
        logic [BIT_AW-1:0] addr;
    } t_mem_req;

    // query answer handed to the output register
    typedef struct packed {
        logic valid;
        logic present;
    } t_result;

endpackage

// File: hdl/bloom_filter_insert_query.sv
// Bloom filter with insert and query over a 1024-bit store. A transaction on the
// slave stream carries a 32-bit key hash (tdata) and the mode (tuser, 0 insert,
// 1 query); each query gives one transaction on the master stream with bit 0 of
// tdata set when every probed bit is set, inserts give none. Round i probes bit
// (key_hash ^ (i << 16)) mod filter_bits. One shared remainder unit takes four
// key bits a cycle, first over the top twelve bits once per item and then over
// the other twenty in each round, and each round makes one access to the bit
// store, which has one write port and one registered read port. A query answer
// waits in the sequencer, holding off the next item, for as long as the output
// register is still full. After reset the store is cleared one bit a cycle, and
// no item is taken until all 1024 bits are cleared; configuration writes are
// taken at any time and must be made while the block is idle.
module bloom_filter_insert_query (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bfiq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] key_hash
    input  logic                                s_axis_tuser,  // [0] mode
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bfiq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [0] maybe_present
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bfiq_pkg::*;

    logic [FB_W-1:0]   r_filter_bits;
    logic [HC_W-1:0]   r_hash_count;
    logic              r_clr_busy;
    logic [BIT_AW-1:0] r_clr_addr;
    logic              r_m_valid;
    logic              r_m_bit;

    logic [MOD_W-1:0]  w_eff_mod;
    logic [RCNT_W-1:0] w_eff_rnd;
    logic              w_seq_ready;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_rd_data;
    t_mem_req          w_req;
    t_result           w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= FB_RESET;
            r_hash_count  <= HC_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FILTER_BITS: r_filter_bits <= i_cfg_data[FB_W-1:0];
                REG_HASH_COUNT:  r_hash_count  <= i_cfg_data[HC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // modulus and round count clamped to what the store supports
    always_comb begin
        if (r_filter_bits == '0) begin
            w_eff_mod = MOD_W'(1);
        end else if (32'(r_filter_bits) > 32'(MAX_BITS)) begin
            w_eff_mod = MOD_W'(MAX_BITS);
        end else begin
            w_eff_mod = MOD_W'(r_filter_bits);
        end
        if (32'(r_hash_count) > 32'(MAX_HASHES)) begin
            w_eff_rnd = RCNT_W'(MAX_HASHES);
        end else begin
            w_eff_rnd = RCNT_W'(r_hash_count);
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + BIT_AW'(1);
            if (r_clr_addr == BIT_AW'(MAX_BITS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // input handshake
    assign s_axis_tready = w_seq_ready & ~r_clr_busy;
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_m_valid | m_axis_tready;

    bfiq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_mode     (s_axis_tuser),
        .i_key      (s_axis_tdata),
        .i_mod      (w_eff_mod),
        .i_rounds   (w_eff_rnd),
        .i_out_free (w_out_free),
        .i_rd_data  (w_rd_data),
        .o_ready    (w_seq_ready),
        .o_req      (w_req),
        .o_res      (w_res)
    );

    // bit store, the sweep owns the write port while it runs
    bfiq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_clr_busy | (w_req.en & w_req.we)),
        .i_waddr (r_clr_busy ? r_clr_addr : w_req.addr),
        .i_wdata (~r_clr_busy),
        .i_raddr (w_req.addr),
        .o_rdata (w_rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_m_bit <= w_res.present;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - 1)'(0), r_m_bit};

    // a result is only produced into a free output register
    a_res_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (!r_m_valid || m_axis_tready))
        else $error("result produced while output register full");

    // the sequencer leaves the store alone during the clearing sweep
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_req.en)
        else $error("store access during clearing sweep");

    // every probed index lies below the modulus in use
    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.en |-> (MOD_W'(w_req.addr) < w_eff_mod))
        else $error("store index not below modulus");

    // one item at a time: ready drops right after a transaction
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

endmodule

// File: hdl/bfiq_ram.sv
module bfiq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bfiq_mod_step.sv
module bfiq_mod_step (
    input  logic [bfiq_pkg::BIT_AW-1:0] i_rem,
    input  logic [bfiq_pkg::DIG-1:0]    i_dig,
    input  logic [bfiq_pkg::MOD_W-1:0]  i_mod,
    output logic [bfiq_pkg::BIT_AW-1:0] o_rem
);
    import bfiq_pkg::*;

    // shift in DIG bits msb first, one compare and subtract per bit
    // the running remainder stays below the modulus, so 2r+b < 2m
    always_comb begin
        logic [MOD_W-1:0]  t;
        logic [BIT_AW-1:0] r;
        r = i_rem;
        t = '0;
        for (int k = 0; k < DIG; k++) begin
            t = {r, i_dig[DIG-1-k]};
            if (t >= i_mod) begin
                t = t - i_mod;
            end
            r = t[BIT_AW-1:0];
        end
        o_rem = r;
    end

endmodule

// File: hdl/bfiq_seq.sv
module bfiq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_mode,
    input  logic [bfiq_pkg::KEY_W-1:0]  i_key,
    input  logic [bfiq_pkg::MOD_W-1:0]  i_mod,
    input  logic [bfiq_pkg::RCNT_W-1:0] i_rounds,
    input  logic                        i_out_free,
    input  logic                        i_rd_data,
    output logic                        o_ready,
    output bfiq_pkg::t_mem_req          o_req,
    output bfiq_pkg::t_result           o_res
);
    import bfiq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state,   n_state;
    logic              r_mode,    n_mode;
    logic [KEY_W-1:0]  r_key,     n_key;
    logic [MOD_W-1:0]  r_mod,     n_mod;
    logic [RCNT_W-1:0] r_rounds,  n_rounds;
    logic [RCNT_W-1:0] r_round,   n_round;
    logic [DCNT_W-1:0] r_dig,     n_dig;
    logic [KEY_W-1:0]  r_shf,     n_shf;
    logic [BIT_AW-1:0] r_rem,     n_rem;
    logic [BIT_AW-1:0] r_pre,     n_pre;
    logic              r_all,     n_all;
    logic              r_rd_pend, n_rd_pend;

    logic [BIT_AW-1:0] w_step;
    logic [RCNT_W-1:0] w_round_inc;
    logic              w_last_pre;
    logic              w_last_low;
    logic              w_last_round;
    logic              w_rd_bit;
    logic [KEY_W-1:0]  w_low_first;
    logic [KEY_W-1:0]  w_low_next;

    // shared remainder unit, fed from the top of the key shifter
    bfiq_mod_step u_step (
        .i_rem (r_rem),
        .i_dig (r_shf[KEY_W-1 -: DIG]),
        .i_mod (r_mod),
        .o_rem (w_step)
    );

    // counters and the low part of the key for the coming round
    assign w_round_inc  = r_round + RCNT_W'(1);
    assign w_last_pre   = (r_dig == DCNT_W'(PRE_STEPS - 1));
    assign w_last_low   = (r_dig == DCNT_W'(LOW_STEPS - 1));
    assign w_last_round = (w_round_inc == r_rounds);
    assign w_low_first  = r_key << PRE_W;
    assign w_low_next   = (r_key ^ (KEY_W'(w_round_inc) << ROUND_SHIFT)) << PRE_W;

    // read data of the previous round's lookup
    assign w_rd_bit = r_rd_pend ? i_rd_data : 1'b1;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_mod     = r_mod;
        n_rounds  = r_rounds;
        n_round   = r_round;
        n_dig     = r_dig;
        n_shf     = r_shf;
        n_rem     = r_rem;
        n_pre     = r_pre;
        n_all     = r_all & w_rd_bit;
        n_rd_pend = 1'b0;
        o_req     = '0;
        o_res     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode   = i_mode;
                    n_key    = i_key;
                    n_mod    = i_mod;
                    n_rounds = i_rounds;
                    n_round  = '0;
                    n_dig    = '0;
                    n_rem    = '0;
                    n_shf    = i_key;
                    n_all    = 1'b1;
                    n_state  = (i_rounds == '0) ? S_DONE : S_PRE;
                end
            end
            S_PRE: begin
                // remainder of the key bits no round touches
                n_rem = w_step;
                n_shf = r_shf << DIG;
                n_dig = r_dig + DCNT_W'(1);
                if (w_last_pre) begin
                    n_pre   = w_step;
                    n_dig   = '0;
                    n_shf   = w_low_first;
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_rem = w_step;
                n_shf = r_shf << DIG;
                n_dig = r_dig + DCNT_W'(1);
                if (w_last_low) begin
                    // index done: set the bit or look it up
                    o_req.en  = 1'b1;
                    o_req.we  = (r_mode == MODE_INSERT);
                    o_req.addr = w_step;
                    n_rd_pend = (r_mode == MODE_QUERY);
                    n_rem     = r_pre;
                    n_dig     = '0;
                    n_round   = w_round_inc;
                    n_shf     = w_low_next;
                    if (w_last_round) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_mode == MODE_INSERT) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_res.valid   = 1'b1;
                    o_res.present = r_all;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_mod    <= n_mod;
        r_rounds <= n_rounds;
        r_round  <= n_round;
        r_dig    <= n_dig;
        r_shf    <= n_shf;
        r_rem    <= n_rem;
        r_pre    <= n_pre;
        r_all    <= n_all;
    end

    assign o_ready = (r_state == S_IDLE);

endmodule
